// File: rtl/jcdm_pkg.sv
// Shared constants, codes and types for the joystick calibration and dead-zone mapper.
// Used by every module of the block; depends on nothing else.
package jcdm_pkg;

   localparam int SAMPLE_BITS = 10;
   localparam int OP_W        = 2;
   localparam int DB_W        = 8;
   localparam int FS_W        = 7;
   localparam int POS_W       = FS_W + 1;
   localparam int EXT_W       = ((SAMPLE_BITS > DB_W) ? SAMPLE_BITS : DB_W) + 3;
   localparam int NUM_W       = SAMPLE_BITS + FS_W;
   localparam int DSH_W       = NUM_W - 1;
   localparam int CNT_W       = $clog2(FS_W);
   localparam int CSR_IDX_W   = 1;

   localparam logic [OP_W-1:0] OP_CALIBRATE = 2'd0;
   localparam logic [OP_W-1:0] OP_IDLE_POS  = 2'd1;
   localparam logic [OP_W-1:0] OP_CONVERT   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 1'd1;

   localparam logic [DB_W-1:0]        DEAD_BAND_RESET  = 8'd5;
   localparam logic [FS_W-1:0]        FULL_SCALE_RESET = 7'd100;
   localparam logic [SAMPLE_BITS:0]   MIN_RESET        = (SAMPLE_BITS + 1)'(1 << SAMPLE_BITS);

   typedef enum logic [1:0] {
      ZONE_DEAD  = 2'd0,
      ZONE_BELOW = 2'd1,
      ZONE_ABOVE = 2'd2
   } zone_type;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_ITER   = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic mul;
      logic check;
      logic step;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/jcdm_ctrl.sv
// Controller state machine: sequences load, multiply, divide steps and result write.
// Depends on jcdm_pkg.
module jcdm_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [jcdm_pkg::OP_W-1:0]    req_opcode,
   output logic                         req_stall,
   input  jcdm_pkg::dp_status_type      status,
   output jcdm_pkg::dp_cmd_type         cmd
);

   localparam int CNT_W = jcdm_pkg::CNT_W;

   jcdm_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign req_stall = (state_ff != jcdm_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         jcdm_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_opcode == jcdm_pkg::OP_CONVERT) ? jcdm_pkg::ST_LOAD
                                                                  : jcdm_pkg::ST_FINISH;
            end
         end
         jcdm_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = jcdm_pkg::ST_MUL;
         end
         jcdm_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = jcdm_pkg::ST_CHECK;
         end
         jcdm_pkg::ST_CHECK: begin
            cmd.check = 1'b1;
            count_in  = CNT_W'(jcdm_pkg::FS_W - 1);
            state_in  = jcdm_pkg::ST_ITER;
         end
         jcdm_pkg::ST_ITER: begin
            cmd.step = 1'b1;
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = jcdm_pkg::ST_FINISH;
            end
         end
         jcdm_pkg::ST_FINISH: begin
            // Wait here until the output register can take the result.
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = jcdm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jcdm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= jcdm_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/jcdm_lane.sv
// One axis of the datapath: calibration state, band test, scaling multiply and
// restoring divider with saturation. Depends on jcdm_pkg.
module jcdm_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  jcdm_pkg::dp_cmd_type               cmd,
   input  logic [jcdm_pkg::OP_W-1:0]          opcode,
   input  logic [jcdm_pkg::SAMPLE_BITS-1:0]   sample,
   input  logic [jcdm_pkg::DB_W-1:0]          dead_band,
   input  logic [jcdm_pkg::FS_W-1:0]          full_scale,
   output logic signed [jcdm_pkg::POS_W-1:0]  position,
   output logic                               fault
);

   localparam int SB    = jcdm_pkg::SAMPLE_BITS;
   localparam int EW    = jcdm_pkg::EXT_W;
   localparam int FS_W  = jcdm_pkg::FS_W;
   localparam int NUM_W = jcdm_pkg::NUM_W;
   localparam int DSH_W = jcdm_pkg::DSH_W;
   localparam int POS_W = jcdm_pkg::POS_W;

   logic [SB-1:0]            max_ff, max_in, idle_ff, idle_in, smp_ff, smp_in;
   logic [SB:0]              min_ff, min_in;
   jcdm_pkg::zone_type       zone_ff, zone_in;
   logic signed [EW-1:0]     div_ff, div_in, dist_ff, dist_in;
   logic [SB-1:0]            divu_ff, divu_in;
   logic [NUM_W-1:0]         num_ff, num_in, rem_ff, rem_in;
   logic [DSH_W-1:0]         dsh_ff, dsh_in;
   logic [FS_W-1:0]          q_ff, q_in;
   logic                     neg_ff, neg_in, fault_ff, fault_in, sat_ff, sat_in;

   logic signed [EW-1:0]     s_s, mn_s, mx_s, idle_s, db_s, lo_s, hi_s;
   logic [SB-1:0]            mag;
   logic                     ge;
   logic signed [POS_W-1:0]  fs_s, q_s;

   // Calibration and idle capture happen as the request is taken.
   always_comb begin
      max_in  = max_ff;
      min_in  = min_ff;
      idle_in = idle_ff;
      smp_in  = smp_ff;
      if (cmd.capture) begin
         smp_in = sample;
         if (opcode == jcdm_pkg::OP_CALIBRATE) begin
            if (sample > max_ff) begin
               max_in = sample;
            end
            if ({1'b0, sample} < min_ff) begin
               min_in = {1'b0, sample};
            end
         end else if (opcode == jcdm_pkg::OP_IDLE_POS) begin
            idle_in = sample;
         end
      end
   end

   // Band edges are signed so that they never wrap.
   always_comb begin
      s_s    = $signed(EW'(smp_ff));
      mn_s   = $signed(EW'(min_ff));
      mx_s   = $signed(EW'(max_ff));
      idle_s = $signed(EW'(idle_ff));
      db_s   = $signed(EW'(dead_band));
      lo_s   = idle_s - db_s;
      hi_s   = idle_s + db_s;
      zone_in = zone_ff;
      div_in  = div_ff;
      dist_in = dist_ff;
      if (cmd.load) begin
         if (s_s < lo_s) begin
            zone_in = jcdm_pkg::ZONE_BELOW;
            div_in  = lo_s - mn_s;
            dist_in = s_s - mn_s;
         end else if (s_s > hi_s) begin
            zone_in = jcdm_pkg::ZONE_ABOVE;
            div_in  = mx_s - hi_s;
            dist_in = s_s - hi_s;
         end else begin
            zone_in = jcdm_pkg::ZONE_DEAD;
            div_in  = '0;
            dist_in = '0;
         end
      end
   end

   // A negative distance only occurs below the minimum and saturates to -full_scale.
   always_comb begin
      mag      = dist_ff[EW-1] ? '0 : dist_ff[SB-1:0];
      num_in   = num_ff;
      divu_in  = divu_ff;
      neg_in   = neg_ff;
      fault_in = fault_ff;
      if (cmd.mul) begin
         num_in   = NUM_W'(mag) * NUM_W'(full_scale);
         divu_in  = div_ff[SB-1:0];
         neg_in   = dist_ff[EW-1];
         fault_in = div_ff[EW-1] || (div_ff == '0);
      end
   end

   // Restoring division; a quotient of 2^FS_W or more is flagged as saturated up front.
   always_comb begin
      ge     = (rem_ff >= NUM_W'(dsh_ff));
      sat_in = sat_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      q_in   = q_ff;
      if (cmd.check) begin
         sat_in = (num_ff >= {divu_ff, {FS_W{1'b0}}});
         rem_in = num_ff;
         dsh_in = {divu_ff, {(FS_W - 1){1'b0}}};
         q_in   = '0;
      end else if (cmd.step) begin
         rem_in = ge ? (rem_ff - NUM_W'(dsh_ff)) : rem_ff;
         dsh_in = dsh_ff >> 1;
         q_in   = {q_ff[FS_W-2:0], ge};
      end
   end

   always_comb begin
      fs_s     = $signed({1'b0, full_scale});
      q_s      = $signed({1'b0, q_ff});
      position = '0;
      fault    = 1'b0;
      case (zone_ff)
         jcdm_pkg::ZONE_DEAD: begin
            position = '0;
         end
         jcdm_pkg::ZONE_BELOW: begin
            fault = fault_ff;
            if (!fault_ff) begin
               position = neg_ff ? -fs_s : (q_s - fs_s);
            end
         end
         jcdm_pkg::ZONE_ABOVE: begin
            fault = fault_ff;
            if (!fault_ff) begin
               position = (sat_ff || (q_s > fs_s)) ? fs_s : q_s;
            end
         end
         default: begin
            position = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff  <= '0;
         min_ff  <= jcdm_pkg::MIN_RESET;
         idle_ff <= '0;
      end else begin
         max_ff  <= max_in;
         min_ff  <= min_in;
         idle_ff <= idle_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff   <= smp_in;
      zone_ff  <= zone_in;
      div_ff   <= div_in;
      dist_ff  <= dist_in;
      divu_ff  <= divu_in;
      num_ff   <= num_in;
      neg_ff   <= neg_in;
      fault_ff <= fault_in;
      sat_ff   <= sat_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
   end

endmodule

// File: rtl/jcdm_dpath.sv
// Datapath: configuration registers, two axis lanes and the result register.
// Depends on jcdm_pkg and jcdm_lane.
module jcdm_dpath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  jcdm_pkg::dp_cmd_type                   cmd,
   output jcdm_pkg::dp_status_type                status,
   input  logic [jcdm_pkg::OP_W-1:0]              req_opcode,
   input  logic [jcdm_pkg::SAMPLE_BITS-1:0]       req_sample_x,
   input  logic [jcdm_pkg::SAMPLE_BITS-1:0]       req_sample_y,
   input  logic                                   csr_valid,
   input  logic [jcdm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jcdm_pkg::DB_W-1:0]              csr_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [jcdm_pkg::POS_W-1:0]      rsp_position_x,
   output logic signed [jcdm_pkg::POS_W-1:0]      rsp_position_y,
   output logic                                   rsp_fault_x,
   output logic                                   rsp_fault_y
);

   localparam int POS_W = jcdm_pkg::POS_W;
   localparam int FS_W  = jcdm_pkg::FS_W;

   logic [jcdm_pkg::DB_W-1:0]  db_ff, db_in;
   logic [FS_W-1:0]            fs_ff, fs_in;
   logic [jcdm_pkg::OP_W-1:0]  op_ff, op_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic                       flt_x_ff, flt_x_in, flt_y_ff, flt_y_in;

   logic signed [POS_W-1:0]    lane_pos_x, lane_pos_y;
   logic                       lane_flt_x, lane_flt_y, is_convert;

   jcdm_lane u_lane_x (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .opcode     (req_opcode),
      .sample     (req_sample_x),
      .dead_band  (db_ff),
      .full_scale (fs_ff),
      .position   (lane_pos_x),
      .fault      (lane_flt_x)
   );

   jcdm_lane u_lane_y (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .opcode     (req_opcode),
      .sample     (req_sample_y),
      .dead_band  (db_ff),
      .full_scale (fs_ff),
      .position   (lane_pos_y),
      .fault      (lane_flt_y)
   );

   always_comb begin
      db_in = db_ff;
      fs_in = fs_ff;
      if (csr_valid) begin
         case (csr_index)
            jcdm_pkg::CSR_DEAD_BAND:  db_in = csr_data;
            jcdm_pkg::CSR_FULL_SCALE: fs_in = csr_data[FS_W-1:0];
            default: ;
         endcase
      end
   end

   assign op_in           = cmd.capture ? req_opcode : op_ff;
   assign is_convert      = (op_ff == jcdm_pkg::OP_CONVERT);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   // Only a convert request reports lane results; everything else answers zero.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      flt_x_in     = flt_x_ff;
      flt_y_in     = flt_y_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         pos_x_in     = is_convert ? lane_pos_x : '0;
         pos_y_in     = is_convert ? lane_pos_y : '0;
         flt_x_in     = is_convert && lane_flt_x;
         flt_y_in     = is_convert && lane_flt_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         db_ff        <= jcdm_pkg::DEAD_BAND_RESET;
         fs_ff        <= jcdm_pkg::FULL_SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         db_ff        <= db_in;
         fs_ff        <= fs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      flt_x_ff <= flt_x_in;
      flt_y_ff <= flt_y_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position_x = pos_x_ff;
   assign rsp_position_y = pos_y_ff;
   assign rsp_fault_x    = flt_x_ff;
   assign rsp_fault_y    = flt_y_ff;

endmodule

// File: rtl/joystick_calibrate_deadzone_map_core.sv
// Top level of the joystick calibration and dead-zone mapper.
// Depends on jcdm_pkg, jcdm_ctrl and jcdm_dpath.
//
// A request carries an opcode and an x and a y sample. Calibrate widens the
// stored min/max per axis, capture idle stores the center position, and
// convert maps each sample to a signed position within +-full_scale. Every
// request produces exactly one result; non-convert requests answer zero.
// A request is taken when req_valid is high and req_stall is low; a result
// is taken when rsp_valid is high and rsp_stall is low.
// A convert request passes from acceptance to the next possible acceptance
// through load, multiply, range check, seven restoring-divider steps
// (one quotient bit each, both axes in parallel) and the result write.
// Calibrate and capture requests go straight to the result write. The
// result is on rsp_ the cycle after the write; the block then already accepts
// the next request while the result waits in the output register. If the
// receiver still stalls when the next result is ready, that result waits
// inside and req_stall stays high. The csr_ port writes dead_band (index 0)
// or full_scale (index 1) and is always ready. Synchronous reset restores
// the default band of 5 and full scale of 100 and clears calibration.
module joystick_calibrate_deadzone_map_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [jcdm_pkg::OP_W-1:0]              req_opcode,
   input  logic [jcdm_pkg::SAMPLE_BITS-1:0]       req_sample_x,
   input  logic [jcdm_pkg::SAMPLE_BITS-1:0]       req_sample_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [jcdm_pkg::POS_W-1:0]      rsp_position_x,
   output logic signed [jcdm_pkg::POS_W-1:0]      rsp_position_y,
   output logic                                   rsp_fault_x,
   output logic                                   rsp_fault_y,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [jcdm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jcdm_pkg::DB_W-1:0]              csr_data
);

   jcdm_pkg::dp_cmd_type     cmd;
   jcdm_pkg::dp_status_type  status;

   assign csr_ready = 1'b1;

   jcdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   jcdm_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_opcode),
      .req_sample_x   (req_sample_x),
      .req_sample_y   (req_sample_y),
      .csr_valid      (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_position_x (rsp_position_x),
      .rsp_position_y (rsp_position_y),
      .rsp_fault_x    (rsp_fault_x),
      .rsp_fault_y    (rsp_fault_y)
   );

endmodule

// File: rtl/jcdm_checker.sv
// Port-level checker for the joystick mapper, attached to the top level by bind.
// Depends on jcdm_pkg and joystick_calibrate_deadzone_map_core.
module jcdm_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [jcdm_pkg::POS_W-1:0]      rsp_position_x,
   input logic signed [jcdm_pkg::POS_W-1:0]      rsp_position_y,
   input logic                                   rsp_fault_x,
   input logic                                   rsp_fault_y
);

   // A faulted axis always reports a centered position.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_fault_x || (rsp_position_x == '0)) &&
                     (!rsp_fault_y || (rsp_position_y == '0))))
      else $error("faulted axis reports a nonzero position");

   // Positions stay symmetric, so the most negative code never appears.
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_position_x != {1'b1, {(jcdm_pkg::POS_W - 1){1'b0}}}) &&
                     (rsp_position_y != {1'b1, {(jcdm_pkg::POS_W - 1){1'b0}}})))
      else $error("position outside the symmetric range");

   // The block works on one request at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while the previous one is in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_position_x) &&
                                    $stable(rsp_position_y)))
      else $error("stalled result changed");

endmodule

bind joystick_calibrate_deadzone_map_core jcdm_checker u_checker (.*);
